### rtl/core/selt_pkg.sv
// shared types and codes of the shared/exclusive lock table
package selt_pkg;

	localparam int NAME_W = 40;
	localparam int TXN_W  = 32;

	typedef enum logic [2:0] {
		CODE_GRANTED    = 3'd0,
		CODE_WAITING    = 3'd1,
		CODE_UNLOCKED   = 3'd2,
		CODE_NO_LOCKS   = 3'd3,
		CODE_TXN_ABSENT = 3'd4,
		CODE_TABLE_FULL = 3'd5,
		CODE_QUEUE_FULL = 3'd6
	} code_t;

	typedef enum logic {
		KIND_RESPONSE = 1'b0,
		KIND_NOTICE   = 1'b1
	} kind_t;

	typedef enum logic {
		CMD_LOCK   = 1'b0,
		CMD_UNLOCK = 1'b1
	} cmd_t;

	typedef enum logic {
		MODE_SHARED    = 1'b0,
		MODE_EXCLUSIVE = 1'b1
	} mode_t;

	typedef struct packed {
		logic [TXN_W-1:0] txn;
		logic             mode;
		logic             granted;
	} record_t;

	typedef struct packed {
		kind_t            kind;
		code_t            code;
		logic [TXN_W-1:0] txn;
		logic             last;
	} result_t;

endpackage

### rtl/core/selt_ifs.sv
// request and result channel interfaces
interface selt_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [39:0] name_high;
	logic [39:0] name_low;
	logic [31:0] txn_id;
	logic        lock_mode;

	modport source (output valid, command, name_high, name_low, txn_id, lock_mode,
		input ready);
	modport sink (input valid, command, name_high, name_low, txn_id, lock_mode,
		output ready);
endinterface

interface selt_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [2:0]  code;
	logic [31:0] txn_out;
	logic        last;

	modport source (output valid, kind, code, txn_out, last, input ready);
	modport sink (input valid, kind, code, txn_out, last, output ready);
endinterface

### rtl/core/shared_exclusive_lock_table_top.sv
// lock table top level: request sequencer around the entry and record memories
//
// req carries one lock or unlock request per word; rsp returns one response word
// followed by a notice word for every waiter granted by that request, in queue
// order, with last set on the final word of the request.
// each request is handled alone: the entry memory is read one entry a cycle to
// find the name, then the resource's queue is read one record a cycle, and a
// release moves each later record up with a read and a write back; the next
// request is taken once the last word sits in the output register.
// reset clears the entry valid flags and the output valid flag; the memories are
// not cleared. a stalled receiver holds the output register, which stops the
// sequencer only when it has a further word to hand over.
module shared_exclusive_lock_table_top
	import selt_pkg::*;
#(
	parameter int RESOURCE_ENTRIES = 16,
	parameter int QUEUE_DEPTH      = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	selt_in_if.sink    req,
	selt_out_if.source rsp
);
	localparam int EW   = RESOURCE_ENTRIES > 1 ? $clog2(RESOURCE_ENTRIES) : 1;
	localparam int ECW  = $clog2(RESOURCE_ENTRIES + 1);
	localparam int QW   = $clog2(QUEUE_DEPTH);
	localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
	localparam int RD   = RESOURCE_ENTRIES * QUEUE_DEPTH;
	localparam int RAW  = $clog2(RD);
	localparam int ENTW = 2 * NAME_W + QCW;
	localparam int RECW = $bits(record_t);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_MISS, ST_QSTART, ST_QSCAN, ST_QDEC,
		ST_REL_RD, ST_REL_WR, ST_REL_END, ST_FIN
	} state_t;

	state_t state_q;

	// latched request
	logic              cmd_q;
	logic [NAME_W-1:0] nh_q, nl_q;
	logic [TXN_W-1:0]  txn_q;
	logic              mode_q;

	logic [RESOURCE_ENTRIES-1:0] valid_q;
	logic [ECW-1:0] e_q;
	logic           cmp_vld_q;
	logic [EW-1:0]  cmp_idx_q;
	logic [EW-1:0]  found_q;
	logic           free_vld_q;
	logic [EW-1:0]  free_q;
	logic [QCW-1:0] cnt_q;
	logic [QCW-1:0] k_q;
	logic           qcmp_vld_q;
	logic [QW-1:0]  qcmp_idx_q;
	logic           p_vld_q;
	logic [QW-1:0]  p_q;
	logic           excl_before_q;
	logic           all_sg_q;
	logic           first_q;
	logic           run_q;

	// pending word, handed over once the next one or the end is known
	kind_t            pend_kind_q;
	code_t            pend_code_q;
	logic [TXN_W-1:0] pend_txn_q;

	logic            ent_we, ent_re;
	logic [EW-1:0]   ent_waddr, ent_raddr;
	logic [ENTW-1:0] ent_wdata, ent_rdata;
	logic            rec_we, rec_re;
	logic [RAW-1:0]  rec_waddr, rec_raddr;
	record_t         rec_wdata, rec_rdata;

	logic    push, push_last, can_push;
	result_t push_item;

	logic hit;
	logic lock_grant;
	logic rel_g, rel_run;
	logic rel_stall;

	function automatic logic [RAW-1:0] rec_addr(input logic [EW-1:0] ent,
		input logic [QCW-1:0] k);
		rec_addr = RAW'(ent) * RAW'(QUEUE_DEPTH) + RAW'(k);
	endfunction

	assign hit = cmp_vld_q && (ent_rdata[ENTW-1 -: NAME_W] == nh_q)
		&& (ent_rdata[QCW +: NAME_W] == nl_q);
	assign lock_grant = (mode_q == MODE_SHARED) && all_sg_q;

	always_comb begin
		if (first_q) begin
			if (rec_rdata.mode)
				rel_g = !excl_before_q && (p_q == '0) && !rec_rdata.granted;
			else
				rel_g = !excl_before_q && !rec_rdata.granted;
			rel_run = !excl_before_q && !rec_rdata.mode && !rec_rdata.granted;
		end else begin
			rel_g   = run_q && !rec_rdata.mode && !rec_rdata.granted;
			rel_run = rel_g;
		end
	end

	assign rel_stall = rel_g && !can_push;
	assign req.ready = (state_q == ST_IDLE);

	always_comb begin
		ent_we    = 1'b0;
		ent_re    = 1'b0;
		ent_waddr = found_q;
		ent_raddr = e_q[EW-1:0];
		ent_wdata = {nh_q, nl_q, cnt_q};
		rec_we    = 1'b0;
		rec_re    = 1'b0;
		rec_waddr = rec_addr(found_q, cnt_q);
		rec_raddr = rec_addr(found_q, k_q);
		rec_wdata = '{txn: txn_q, mode: mode_q, granted: lock_grant};
		push      = 1'b0;
		push_last = 1'b0;
		case (state_q)
			ST_SCAN: begin
				ent_re = (e_q != ECW'(RESOURCE_ENTRIES)) && !hit;
			end
			ST_MISS: begin
				if (cmd_q == CMD_LOCK && free_vld_q) begin
					ent_we    = 1'b1;
					ent_waddr = free_q;
					ent_wdata = {nh_q, nl_q, QCW'(1)};
					rec_we    = 1'b1;
					rec_waddr = rec_addr(free_q, '0);
					rec_wdata = '{txn: txn_q, mode: mode_q, granted: 1'b1};
				end
			end
			ST_QSCAN: begin
				rec_re = (k_q < cnt_q);
			end
			ST_QDEC: begin
				if (cmd_q == CMD_LOCK) begin
					rec_we = 1'b1;
					if (!p_vld_q) begin
						ent_we    = 1'b1;
						ent_wdata = {nh_q, nl_q, cnt_q + QCW'(1)};
					end
				end
			end
			ST_REL_RD: begin
				rec_re = (k_q < cnt_q);
			end
			ST_REL_WR: begin
				rec_we    = !rel_stall;
				rec_waddr = rec_addr(found_q, k_q - QCW'(1));
				rec_wdata = '{txn: rec_rdata.txn, mode: rec_rdata.mode,
					granted: rec_rdata.granted | rel_g};
				push      = rel_g && can_push;
			end
			ST_REL_END: begin
				ent_we    = 1'b1;
				ent_wdata = {nh_q, nl_q, cnt_q - QCW'(1)};
			end
			ST_FIN: begin
				push      = can_push;
				push_last = 1'b1;
			end
			default: ;
		endcase
	end

	assign push_item = '{kind: pend_kind_q, code: pend_code_q, txn: pend_txn_q,
		last: push_last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			valid_q       <= '0;
			e_q           <= '0;
			cmp_vld_q     <= 1'b0;
			cmp_idx_q     <= '0;
			found_q       <= '0;
			free_vld_q    <= 1'b0;
			free_q        <= '0;
			cnt_q         <= '0;
			k_q           <= '0;
			qcmp_vld_q    <= 1'b0;
			qcmp_idx_q    <= '0;
			p_vld_q       <= 1'b0;
			p_q           <= '0;
			excl_before_q <= 1'b0;
			all_sg_q      <= 1'b0;
			first_q       <= 1'b0;
			run_q         <= 1'b0;
			cmd_q         <= 1'b0;
			nh_q          <= '0;
			nl_q          <= '0;
			txn_q         <= '0;
			mode_q        <= 1'b0;
			pend_kind_q   <= KIND_RESPONSE;
			pend_code_q   <= CODE_GRANTED;
			pend_txn_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cmd_q      <= req.command;
						nh_q       <= req.name_high;
						nl_q       <= req.name_low;
						txn_q      <= req.txn_id;
						mode_q     <= req.lock_mode;
						e_q        <= '0;
						cmp_vld_q  <= 1'b0;
						free_vld_q <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// compare the entry read last cycle while reading the next
					if (hit) begin
						found_q   <= cmp_idx_q;
						cnt_q     <= ent_rdata[QCW-1:0];
						cmp_vld_q <= 1'b0;
						state_q   <= ST_QSTART;
					end else if (e_q == ECW'(RESOURCE_ENTRIES)) begin
						cmp_vld_q <= 1'b0;
						state_q   <= ST_MISS;
					end else begin
						cmp_vld_q <= valid_q[e_q[EW-1:0]];
						cmp_idx_q <= e_q[EW-1:0];
						if (!valid_q[e_q[EW-1:0]] && !free_vld_q) begin
							free_vld_q <= 1'b1;
							free_q     <= e_q[EW-1:0];
						end
						e_q <= e_q + ECW'(1);
					end
				end
				ST_MISS: begin
					pend_kind_q <= KIND_RESPONSE;
					pend_txn_q  <= txn_q;
					if (cmd_q == CMD_UNLOCK)
						pend_code_q <= CODE_NO_LOCKS;
					else if (!free_vld_q)
						pend_code_q <= CODE_TABLE_FULL;
					else begin
						pend_code_q     <= CODE_GRANTED;
						valid_q[free_q] <= 1'b1;
					end
					state_q <= ST_FIN;
				end
				ST_QSTART: begin
					pend_kind_q <= KIND_RESPONSE;
					pend_txn_q  <= txn_q;
					if (cmd_q == CMD_LOCK && cnt_q >= QCW'(QUEUE_DEPTH)) begin
						pend_code_q <= CODE_QUEUE_FULL;
						state_q     <= ST_FIN;
					end else begin
						k_q           <= '0;
						qcmp_vld_q    <= 1'b0;
						p_vld_q       <= 1'b0;
						excl_before_q <= 1'b0;
						all_sg_q      <= 1'b1;
						state_q       <= ST_QSCAN;
					end
				end
				ST_QSCAN: begin
					if (qcmp_vld_q) begin
						if (!p_vld_q) begin
							if (rec_rdata.txn == txn_q) begin
								p_vld_q <= 1'b1;
								p_q     <= qcmp_idx_q;
							end else if (rec_rdata.mode) begin
								excl_before_q <= 1'b1;
							end
						end
						if (rec_rdata.mode || !rec_rdata.granted)
							all_sg_q <= 1'b0;
					end
					if (k_q < cnt_q) begin
						qcmp_vld_q <= 1'b1;
						qcmp_idx_q <= k_q[QW-1:0];
						k_q        <= k_q + QCW'(1);
					end else begin
						qcmp_vld_q <= 1'b0;
						if (!qcmp_vld_q)
							state_q <= ST_QDEC;
					end
				end
				ST_QDEC: begin
					first_q <= 1'b1;
					run_q   <= 1'b0;
					k_q     <= QCW'(p_q) + QCW'(1);
					if (cmd_q == CMD_UNLOCK) begin
						if (!p_vld_q) begin
							pend_code_q <= CODE_TXN_ABSENT;
							state_q     <= ST_FIN;
						end else begin
							pend_code_q <= CODE_UNLOCKED;
							state_q     <= ST_REL_RD;
						end
					end else begin
						pend_code_q <= lock_grant ? CODE_GRANTED : CODE_WAITING;
						cnt_q       <= cnt_q + QCW'(1);
						state_q     <= p_vld_q ? ST_REL_RD : ST_FIN;
					end
				end
				ST_REL_RD: begin
					state_q <= (k_q < cnt_q) ? ST_REL_WR : ST_REL_END;
				end
				ST_REL_WR: begin
					if (!rel_stall) begin
						if (rel_g) begin
							pend_kind_q <= KIND_NOTICE;
							pend_code_q <= CODE_GRANTED;
							pend_txn_q  <= rec_rdata.txn;
						end
						first_q <= 1'b0;
						run_q   <= rel_run;
						k_q     <= k_q + QCW'(1);
						state_q <= ST_REL_RD;
					end
				end
				ST_REL_END: begin
					if (cnt_q == QCW'(1))
						valid_q[found_q] <= 1'b0;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (can_push)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	selt_ram #(.WIDTH(ENTW), .DEPTH(RESOURCE_ENTRIES)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	selt_ram #(.WIDTH(RECW), .DEPTH(RD)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.re    (rec_re),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	selt_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (push_item),
		.can_push (can_push),
		.rsp      (rsp)
	);
endmodule

### rtl/core/selt_ram.sv
// generic single write port ram with registered read
module selt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

### rtl/core/selt_emit.sv
// output register for result words
module selt_emit
	import selt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  result_t     item,
	output logic        can_push,
	selt_out_if.source  rsp
);
	logic    vld_q;
	result_t item_q;

	assign can_push = !vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (can_push) begin
			vld_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (can_push && push)
			item_q <= item;
	end

	assign rsp.valid   = vld_q;
	assign rsp.kind    = item_q.kind;
	assign rsp.code    = item_q.code;
	assign rsp.txn_out = item_q.txn;
	assign rsp.last    = item_q.last;
endmodule

### verif/tb_shared_exclusive_lock_table_top.sv
// testbench for the shared/exclusive lock table: random lock traffic against a scoreboard
module tb_shared_exclusive_lock_table_top;
	timeunit 1ns;
	timeprecision 1ps;
	import selt_pkg::*;

	localparam int ENTRIES = 16;
	localparam int DEPTH   = 8;
	localparam int LIMIT   = 400000;

	typedef struct {
		logic        command;
		logic [39:0] nh;
		logic [39:0] nl;
		logic [31:0] txn;
		logic        mode;
	} lock_req_t;

	// holds the predicted lock table and the words still owed by the block
	class lock_scoreboard;
		bit          ent_valid [ENTRIES];
		logic [39:0] ent_nh [ENTRIES];
		logic [39:0] ent_nl [ENTRIES];
		int          ent_count [ENTRIES];
		record_t     recs [ENTRIES][DEPTH];
		result_t     owed [$];
		int          mismatches;

		function void push(kind_t k, code_t c, logic [31:0] t);
			result_t r;
			r.kind = k;
			r.code = c;
			r.txn = t;
			r.last = 1'b0;
			owed.push_back(r);
		endfunction

		function int find_txn(int e, logic [31:0] t);
			for (int k = 0; k < ent_count[e]; k++)
				if (recs[e][k].txn == t)
					return k;
			return -1;
		endfunction

		function void release_rec(int e, int pos);
			bit all_shared;
			int k;
			int cnt;
			cnt = ent_count[e];
			all_shared = 1;
			for (k = 0; k < pos; k++)
				if (recs[e][k].mode != MODE_SHARED)
					all_shared = 0;
			k = pos + 1;
			if (all_shared && k < cnt) begin
				if (recs[e][k].mode != MODE_SHARED) begin
					if (pos == 0 && !recs[e][k].granted) begin
						recs[e][k].granted = 1;
						push(KIND_NOTICE, CODE_GRANTED, recs[e][k].txn);
					end
				end else begin
					while (k < cnt && recs[e][k].mode == MODE_SHARED
						&& !recs[e][k].granted) begin
						recs[e][k].granted = 1;
						push(KIND_NOTICE, CODE_GRANTED, recs[e][k].txn);
						k++;
					end
				end
			end
			for (k = pos; k + 1 < cnt; k++)
				recs[e][k] = recs[e][k+1];
			ent_count[e] = cnt - 1;
			if (ent_count[e] == 0)
				ent_valid[e] = 0;
		endfunction

		function void note_request(lock_req_t q);
			int found;
			int p;
			int cnt;
			bit grant;
			found = -1;
			for (int e = 0; e < ENTRIES; e++)
				if (found < 0 && ent_valid[e] && ent_nh[e] == q.nh && ent_nl[e] == q.nl)
					found = e;
			if (q.command == CMD_UNLOCK) begin
				if (found < 0 || ent_count[found] == 0)
					push(KIND_RESPONSE, CODE_NO_LOCKS, q.txn);
				else begin
					p = find_txn(found, q.txn);
					if (p < 0)
						push(KIND_RESPONSE, CODE_TXN_ABSENT, q.txn);
					else begin
						push(KIND_RESPONSE, CODE_UNLOCKED, q.txn);
						release_rec(found, p);
					end
				end
			end else if (found >= 0 && ent_count[found] > 0) begin
				cnt = ent_count[found];
				if (cnt >= DEPTH)
					push(KIND_RESPONSE, CODE_QUEUE_FULL, q.txn);
				else begin
					p = find_txn(found, q.txn);
					grant = (q.mode == MODE_SHARED);
					for (int k = 0; k < cnt; k++)
						if (recs[found][k].mode != MODE_SHARED || !recs[found][k].granted)
							grant = 0;
					recs[found][cnt] = '{txn: q.txn, mode: q.mode, granted: grant};
					ent_count[found] = cnt + 1;
					push(KIND_RESPONSE, grant ? CODE_GRANTED : CODE_WAITING, q.txn);
					if (p >= 0)
						release_rec(found, p);
				end
			end else begin
				if (found < 0)
					for (int e = 0; e < ENTRIES; e++)
						if (found < 0 && !ent_valid[e])
							found = e;
				if (found < 0)
					push(KIND_RESPONSE, CODE_TABLE_FULL, q.txn);
				else begin
					ent_valid[found] = 1;
					ent_nh[found] = q.nh;
					ent_nl[found] = q.nl;
					ent_count[found] = 1;
					recs[found][0] = '{txn: q.txn, mode: q.mode, granted: 1'b1};
					push(KIND_RESPONSE, CODE_GRANTED, q.txn);
				end
			end
			owed[$].last = 1'b1;
		endfunction

		function bit check_word(result_t got);
			result_t exp;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: kind %0d code %0d txn %h last %0d",
						got.kind, got.code, got.txn, got.last);
				return 0;
			end
			exp = owed.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("word mismatch: exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
						exp.kind, exp.code, exp.txn, exp.last,
						got.kind, got.code, got.txn, got.last);
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	selt_in_if  req ();
	selt_out_if rsp ();

	shared_exclusive_lock_table_top #(.RESOURCE_ENTRIES(ENTRIES), .QUEUE_DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	always #6 clk = ~clk;

	lock_scoreboard sb = new();
	bit     quiet;
	bit     hold_rsp;
	longint cycles;

	initial begin
		req.valid <= 0;
		req.command <= 0;
		req.name_high <= 0;
		req.name_low <= 0;
		req.txn_id <= 0;
		req.lock_mode <= 0;
		rsp.ready <= 0;
	end

	// receiver: random stall bursts, plus a long hold when asked
	initial begin
		result_t w;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				w.kind = kind_t'(rsp.kind);
				w.code = code_t'(rsp.code);
				w.txn = rsp.txn_out;
				w.last = rsp.last;
				void'(sb.check_word(w));
			end
			if (hold_rsp)
				rsp.ready <= 0;
			else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 0;
				repeat ($urandom_range(1, 11)) @(posedge clk) begin
					if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
						w.kind = kind_t'(rsp.kind);
						w.code = code_t'(rsp.code);
						w.txn = rsp.txn_out;
						w.last = rsp.last;
						void'(sb.check_word(w));
					end
				end
				rsp.ready <= 1;
			end else
				rsp.ready <= 1;
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send(lock_req_t q);
		req.valid <= 1;
		req.command <= q.command;
		req.name_high <= q.nh;
		req.name_low <= q.nl;
		req.txn_id <= q.txn;
		req.lock_mode <= q.mode;
		do @(posedge clk); while (req.ready !== 1'b1);
		sb.note_request(q);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req.valid <= 0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic idle_req();
		req.valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		idle_req();
		while (sb.owed.size() != 0)
			@(posedge clk);
	endtask

	// small pools of names and transactions so queues meet and fill
	function automatic lock_req_t pick(int names, int txns);
		lock_req_t q;
		int n;
		n = $urandom_range(0, names - 1);
		q.command = ($urandom_range(0, 9) < 4) ? CMD_UNLOCK : CMD_LOCK;
		q.nh = {8'h52, 24'h0, 8'(n)};
		q.nl = {32'h0, 8'(n * 7)};
		if ($urandom_range(0, 15) == 0) begin
			q.nh = {$urandom, 8'($urandom)};
			q.nl = {$urandom, 8'($urandom)};
		end
		q.txn = 32'h1000 + $urandom_range(0, txns - 1);
		if ($urandom_range(0, 19) == 0)
			q.txn = $urandom;
		q.mode = 1'($urandom_range(0, 1));
		return q;
	endfunction

	initial begin
		lock_req_t q;
		quiet = 0;
		hold_rsp = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, empty unlock, sharing, waiters, queue full
		q = '{CMD_UNLOCK, 40'h0, 40'h0, 32'h0, MODE_SHARED};
		send(q);
		q = '{CMD_LOCK, {40{1'b1}}, {40{1'b1}}, 32'hFFFF_FFFF, MODE_EXCLUSIVE};
		send(q);
		q = '{CMD_LOCK, {40{1'b1}}, {40{1'b1}}, 32'h0, MODE_SHARED};
		send(q);
		q = '{CMD_UNLOCK, {40{1'b1}}, {40{1'b1}}, 32'h5, MODE_SHARED};
		send(q);
		q = '{CMD_UNLOCK, {40{1'b1}}, {40{1'b1}}, 32'hFFFF_FFFF, MODE_SHARED};
		send(q);
		for (int i = 0; i < 3; i++) begin
			q = '{CMD_LOCK, 40'h1, 40'h2, 32'(i + 1), MODE_SHARED};
			send(q);
		end
		q = '{CMD_LOCK, 40'h1, 40'h2, 32'h9, MODE_EXCLUSIVE};
		send(q);
		for (int i = 0; i < 5; i++) begin
			q = '{CMD_LOCK, 40'h1, 40'h2, 32'(20 + i), (i == 2) ? MODE_EXCLUSIVE : MODE_SHARED};
			send(q);
		end
		// relock by a queued transaction, then unlock the head runs
		q = '{CMD_LOCK, 40'h1, 40'h2, 32'h1, MODE_SHARED};
		send(q);
		for (int i = 1; i <= 3; i++) begin
			q = '{CMD_UNLOCK, 40'h1, 40'h2, 32'(i), MODE_SHARED};
			send(q);
		end
		q = '{CMD_UNLOCK, 40'h1, 40'h2, 32'h9, MODE_SHARED};
		send(q);
		// fill the table to reach the full-table answer
		for (int i = 0; i < 16; i++) begin
			q = '{CMD_LOCK, 40'h7700 + i, 40'h0, 32'h77, MODE_EXCLUSIVE};
			send(q);
		end
		for (int i = 0; i < 16; i++) begin
			q = '{CMD_UNLOCK, 40'h7700 + i, 40'h0, 32'h77, MODE_SHARED};
			send(q);
		end

		// sender pauses until everything is back
		drain();

		// long receiver hold while requests keep coming
		hold_rsp = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_rsp = 0;
			end
			for (int i = 0; i < 20; i++)
				send(pick(4, 6));
		join

		for (int i = 0; i < 210; i++) begin
			if (i == 170)
				quiet = 1;
			send(pick((i < 100) ? 4 : 20, (i < 100) ? 6 : 12));
		end
		drain();
		repeat (60) @(posedge clk);

		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

### sim.f
rtl/core/selt_pkg.sv
rtl/core/selt_ifs.sv
rtl/core/selt_ram.sv
rtl/core/selt_emit.sv
rtl/core/shared_exclusive_lock_table_top.sv
verif/tb_shared_exclusive_lock_table_top.sv
